/* hw/rtl/mvt_pkg.sv */
// Shared types and constants for the 4x4 matrix-vector transform.
`timescale 1ns / 1ps
package mvt_pkg;

    localparam int unsigned DIM      = 4;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned Q_W      = 32;
    localparam int unsigned PROD_W   = 2 * Q_W;
    localparam int unsigned ACC_W    = PROD_W + 2;
    localparam int unsigned FRAC_W   = 16;

    localparam logic CMD_LOAD      = 1'b0;
    localparam logic CMD_TRANSFORM = 1'b1;

    localparam logic signed [Q_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef logic signed [Q_W-1:0]    t_q16;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    // One request as it travels down the cell chain.
    typedef struct packed {
        logic                 cmd;
        logic [IDX_W-1:0]     idx;
        t_q16                 value;
        t_q16 [DIM-1:0]       vec;
    } t_item;

endpackage

/* hw/rtl/matrix4_vector_transform.sv */
// Top level of the 4x4 Q16.16 matrix-vector transform.
`timescale 1ns / 1ps
// Usage:
//   Slave stream carries requests. tuser bit 0 is cmd: 0 loads one matrix
//   coefficient (coef_index = row*4+column, coef_value), 1 transforms the
//   vector x, y, z, w. A load gives no result; a transform gives one result
//   on the master stream: out_x..out_w in tdata and overflow in tuser.
//   Each output component is one matrix row dotted with the vector, summed
//   at full width, truncated toward minus infinity to Q16.16 and saturated.
//   Throughput: one request per cycle while the receiver does not stall,
//   loads and transforms freely mixed. Each column cell registers the
//   multiply, then the accumulate; a saturating output register follows.
//   Loads travel down the same chain, so every transform sees exactly the
//   loads that were requested before it.
//   Reset clears the chain and sets the matrix to the identity.
//   When the receiver stalls while a result waits, the whole chain holds
//   and s_axis_tready drops; no request or result is lost.
module matrix4_vector_transform (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    // [3:0] coef_index, [35:4] coef_value, [67:36] vec_x, [99:68] vec_y,
    // [131:100] vec_z, [163:132] vec_w, [167:164] zero
    input  logic [167:0]   i_s_axis_tdata,
    // [0] cmd
    input  logic [0:0]     i_s_axis_tuser,
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    // [31:0] out_x, [63:32] out_y, [95:64] out_z, [127:96] out_w
    output logic [127:0]   o_m_axis_tdata,
    // [0] overflow
    output logic [0:0]     o_m_axis_tuser
);
    import mvt_pkg::*;

    logic               w_en;
    logic               w_valid [DIM+1];
    t_item              w_item  [DIM+1];
    t_acc  [DIM-1:0]    w_acc   [DIM+1];
    t_q16  [DIM-1:0]    w_res;
    logic               w_ovf;

    // Advance the whole chain unless a finished result is still waiting.
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // Unpack the request into the chain's head.
    assign w_valid[0]      = i_s_axis_tvalid;
    assign w_item[0].cmd   = i_s_axis_tuser[0];
    assign w_item[0].idx   = i_s_axis_tdata[3:0];
    assign w_item[0].value = i_s_axis_tdata[35:4];
    assign w_item[0].vec[0] = i_s_axis_tdata[67:36];
    assign w_item[0].vec[1] = i_s_axis_tdata[99:68];
    assign w_item[0].vec[2] = i_s_axis_tdata[131:100];
    assign w_item[0].vec[3] = i_s_axis_tdata[163:132];
    assign w_acc[0]        = '0;

    // One cell per matrix column; each adds its column's products to the row sums.
    for (genvar c = 0; c < DIM; c++) begin : g_cell
        mvt_cell #(
            .COL (c)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[c]),
            .i_item  (w_item[c]),
            .i_acc   (w_acc[c]),
            .o_valid (w_valid[c+1]),
            .o_item  (w_item[c+1]),
            .o_acc   (w_acc[c+1])
        );
    end

    // Drop loads here; saturate and hold transform results.
    mvt_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_valid[DIM]),
        .i_cmd   (w_item[DIM].cmd),
        .i_acc   (w_acc[DIM]),
        .o_valid (o_m_axis_tvalid),
        .o_res   (w_res),
        .o_ovf   (w_ovf)
    );

    assign o_m_axis_tdata = {w_res[3], w_res[2], w_res[1], w_res[0]};
    assign o_m_axis_tuser = w_ovf;

endmodule

/* hw/rtl/mvt_cell.sv */
// One column cell: holds a matrix column, multiplies and accumulates row sums.
`timescale 1ns / 1ps
module mvt_cell #(
    parameter int unsigned COL = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  mvt_pkg::t_item         i_item,
    input  mvt_pkg::t_acc [3:0]    i_acc,
    output logic                   o_valid,
    output mvt_pkg::t_item         o_item,
    output mvt_pkg::t_acc [3:0]    o_acc
);
    import mvt_pkg::*;

    t_q16               r_coef [DIM];
    logic               r_s1_valid;
    t_item              r_s1_item;
    t_acc  [DIM-1:0]    r_s1_acc;
    t_prod              r_prod [DIM];
    logic               r_s2_valid;
    t_item              r_s2_item;
    t_acc  [DIM-1:0]    r_s2_acc;
    logic               w_load_here;

    assign w_load_here = i_valid && (i_item.cmd == CMD_LOAD)
                         && (i_item.idx[1:0] == COL[1:0]);

    // Column coefficients, reset to the identity column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < DIM; r++) begin
                r_coef[r] <= (r == int'(COL)) ? Q_ONE : '0;
            end
        end else if (i_en && w_load_here) begin
            r_coef[i_item.idx[3:2]] <= i_item.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_item <= i_item;
            r_s1_acc  <= i_acc;
            r_s2_item <= r_s1_item;
            for (int r = 0; r < DIM; r++) begin
                r_prod[r]   <= $signed(r_coef[r]) * $signed(i_item.vec[COL]);
                r_s2_acc[r] <= r_s1_acc[r] + {{(ACC_W-PROD_W){r_prod[r][PROD_W-1]}}, r_prod[r]};
            end
        end
    end

    assign o_valid = r_s2_valid;
    assign o_item  = r_s2_item;
    assign o_acc   = r_s2_acc;

endmodule

/* hw/rtl/mvt_sat.sv */
// Output stage: drop the fraction bits, saturate and hold the result.
`timescale 1ns / 1ps
module mvt_sat (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic                   i_cmd,
    input  mvt_pkg::t_acc [3:0]    i_acc,
    output logic                   o_valid,
    output mvt_pkg::t_q16 [3:0]    o_res,
    output logic                   o_ovf
);
    import mvt_pkg::*;

    localparam int unsigned TOP_W = ACC_W - FRAC_W - Q_W + 1;

    logic               r_valid;
    t_q16 [DIM-1:0]     r_res;
    logic               r_ovf;
    t_q16 [DIM-1:0]     w_res;
    logic [DIM-1:0]     w_ovf;

    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            // Bits above the 32-bit result must all match its sign bit.
            w_ovf[r] = !((&i_acc[r][ACC_W-1 -: TOP_W]) || !(|i_acc[r][ACC_W-1 -: TOP_W]));
            if (w_ovf[r]) begin
                w_res[r] = i_acc[r][ACC_W-1] ? Q_MIN : Q_MAX;
            end else begin
                w_res[r] = i_acc[r][FRAC_W +: Q_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid && (i_cmd == CMD_TRANSFORM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= w_res;
            r_ovf <= |w_ovf;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_ovf   = r_ovf;

endmodule
